// ----- rtl/foiq_pkg.sv -----
`timescale 1ns / 1ps

package foiq_pkg;

  localparam int FRAME_W    = 32;
  localparam int WORD_W     = 16;
  localparam int IN_DATA_W  = 80;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_USER_W = 2;

  // in_tdata field positions
  localparam int IN_FRAME_LSB  = 0;
  localparam int IN_SEED_LSB   = 32;
  localparam int IN_LAST_LSB   = 48;
  localparam int IN_REPLAY_LSB = 64;

  // tuser bit positions
  localparam int IN_OPCODE_BIT   = 0;
  localparam int IN_SIDE_BIT     = 1;
  localparam int OUT_PRED_BIT    = 0;
  localparam int OUT_DROPPED_BIT = 1;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic [WORD_W-1:0]  word;
    logic [WORD_W-1:0]  seed;
    logic               predicted;
  } entry_t;

  // command broadcast to every cell of one queue
  typedef struct packed {
    logic   ins;
    logic   pop;
    entry_t new_entry;
  } ctl_t;

  // ripple between neighboring cells
  typedef struct packed {
    logic found;
    logic shift;
  } link_t;

endpackage

// ----- rtl/foiq_cell.sv -----
`timescale 1ns / 1ps

module foiq_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  foiq_pkg::ctl_t  ctl,
  input  foiq_pkg::entry_t prev_entry,
  input  foiq_pkg::entry_t next_entry,
  input  foiq_pkg::link_t link_in,
  output foiq_pkg::link_t link_out,
  output foiq_pkg::entry_t entry
);

  foiq_pkg::entry_t entry_r;
  foiq_pkg::entry_t entry_nxt;
  logic             occupied;
  logic             later;
  logic             is_slot;

  assign occupied = (entry_r.frame != '0);
  assign later    = $signed(entry_r.frame) > $signed(ctl.new_entry.frame);
  assign is_slot  = (!occupied || later) && !link_in.found;

  assign link_out.found = link_in.found || !occupied || later;
  assign link_out.shift = link_in.shift || (is_slot && occupied);

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins) begin
      if (is_slot) begin
        entry_nxt = ctl.new_entry;
      end else if (link_in.shift) begin
        entry_nxt = prev_entry;
      end
    end else if (ctl.pop) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
    end else begin
      entry_r <= entry_nxt;
    end
  end

  assign entry = entry_r;

endmodule

// ----- rtl/foiq_queue.sv -----
`timescale 1ns / 1ps

module foiq_queue #(
  parameter int QUEUE_DEPTH = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  foiq_pkg::ctl_t   ctl,
  output foiq_pkg::entry_t head,
  output logic             no_slot
);

  foiq_pkg::entry_t entries [QUEUE_DEPTH];
  foiq_pkg::link_t  links   [QUEUE_DEPTH+1];

  assign links[0] = '0;

  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
    foiq_pkg::entry_t prev_e;
    foiq_pkg::entry_t next_e;

    // head never shifts in; tail keeps its value on pop
    if (k == 0) begin : g_first
      assign prev_e = ctl.new_entry;
    end else begin : g_mid_prev
      assign prev_e = entries[k-1];
    end
    if (k == QUEUE_DEPTH-1) begin : g_last
      assign next_e = entries[k];
    end else begin : g_mid_next
      assign next_e = entries[k+1];
    end

    foiq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .prev_entry (prev_e),
      .next_entry (next_e),
      .link_in    (links[k]),
      .link_out   (links[k+1]),
      .entry      (entries[k])
    );
  end

  assign head    = entries[0];
  assign no_slot = !links[QUEUE_DEPTH].found;

endmodule

// ----- rtl/frame_ordered_input_queue_core.sv -----
`timescale 1ns / 1ps

// Frame-ordered input queue: SIDE_COUNT independent queues of QUEUE_DEPTH
// entries, each entry a cell in a shift chain.
// Input beat (in_*): in_tuser selects the operation and the queue. An insert
// places a predicted entry in signed frame order; later entries move back one
// cell and the tail falls off. A pop returns the head and moves the rest
// forward. A side not below SIDE_COUNT leaves the queues alone.
// Result beat (out_*): exactly one per input beat, in order. Pop gives the
// head seed, mark and input word (the replay word when the head is
// predicted); insert gives zeros, with the dropped flag set when every entry
// holds an earlier or equal frame.
// The result beat is registered, and one beat is taken every cycle while the
// receiver does not stall. The cycle is set by the compare and the found/shift ripple
// through the cell chain of the addressed queue.
// Reset clears every entry to frame 0 (empty) and drops any pending result.
// While the receiver stalls, the result register holds and in_tready is low;
// the beat after a taken result is accepted in the same cycle.
module frame_ordered_input_queue_core #(
  parameter int QUEUE_DEPTH = 10,
  parameter int SIDE_COUNT  = 2
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // frame_number[31:0], seed_value, last_received_input, replay_input
  input  logic [foiq_pkg::IN_DATA_W-1:0]    in_tdata,
  // opcode, side
  input  logic [foiq_pkg::IN_USER_W-1:0]    in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // popped_input, popped_seed
  output logic [foiq_pkg::OUT_DATA_W-1:0]   out_tdata,
  // popped_predicted, insert_dropped
  output logic [foiq_pkg::OUT_USER_W-1:0]   out_tuser
);

  logic                               in_accept;
  logic                               opcode;
  logic                               side;
  logic [foiq_pkg::FRAME_W-1:0]       frame_number;
  logic [foiq_pkg::WORD_W-1:0]        seed_value;
  logic [foiq_pkg::WORD_W-1:0]        last_received_input;
  logic [foiq_pkg::WORD_W-1:0]        replay_input;

  foiq_pkg::ctl_t                     ctl   [SIDE_COUNT];
  foiq_pkg::entry_t                   heads [SIDE_COUNT];
  logic [SIDE_COUNT-1:0]              no_slot;
  logic [SIDE_COUNT-1:0]              side_hit;

  logic                               out_valid_r;
  logic                               out_valid_nxt;
  logic [foiq_pkg::OUT_DATA_W-1:0]    out_data_r;
  logic [foiq_pkg::OUT_DATA_W-1:0]    out_data_nxt;
  logic [foiq_pkg::OUT_USER_W-1:0]    out_user_r;
  logic [foiq_pkg::OUT_USER_W-1:0]    out_user_nxt;

  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  assign opcode              = in_tuser[foiq_pkg::IN_OPCODE_BIT];
  assign side                = in_tuser[foiq_pkg::IN_SIDE_BIT];
  assign frame_number        = in_tdata[foiq_pkg::IN_FRAME_LSB +: foiq_pkg::FRAME_W];
  assign seed_value          = in_tdata[foiq_pkg::IN_SEED_LSB +: foiq_pkg::WORD_W];
  assign last_received_input = in_tdata[foiq_pkg::IN_LAST_LSB +: foiq_pkg::WORD_W];
  assign replay_input        = in_tdata[foiq_pkg::IN_REPLAY_LSB +: foiq_pkg::WORD_W];

  for (genvar s = 0; s < SIDE_COUNT; s++) begin : g_side
    assign side_hit[s]                = (32'(side) == 32'(s));
    assign ctl[s].ins                 = in_accept && side_hit[s] && (opcode == foiq_pkg::OP_INSERT);
    assign ctl[s].pop                 = in_accept && side_hit[s] && (opcode == foiq_pkg::OP_POP);
    assign ctl[s].new_entry.frame     = frame_number;
    assign ctl[s].new_entry.word      = last_received_input;
    assign ctl[s].new_entry.seed      = seed_value;
    assign ctl[s].new_entry.predicted = 1'b1;

    foiq_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl[s]),
      .head    (heads[s]),
      .no_slot (no_slot[s])
    );
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_accept) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '0;
      out_user_nxt  = '0;
      for (int s = 0; s < SIDE_COUNT; s++) begin
        if (side_hit[s]) begin
          if (opcode == foiq_pkg::OP_POP) begin
            out_data_nxt[foiq_pkg::WORD_W-1:0] = heads[s].predicted ?
                                                 replay_input : heads[s].word;
            out_data_nxt[foiq_pkg::OUT_DATA_W-1:foiq_pkg::WORD_W] = heads[s].seed;
            out_user_nxt[foiq_pkg::OUT_PRED_BIT] = heads[s].predicted;
          end else begin
            out_user_nxt[foiq_pkg::OUT_DROPPED_BIT] = no_slot[s];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

`ifndef SYNTHESIS
  a_pop_never_drops: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (opcode == foiq_pkg::OP_POP) |=> !out_tuser[foiq_pkg::OUT_DROPPED_BIT])
    else $error("pop beat reported a dropped insert");

  a_insert_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (opcode == foiq_pkg::OP_INSERT)
      |=> (out_tdata == '0) && !out_tuser[foiq_pkg::OUT_PRED_BIT])
    else $error("insert beat carried pop payload");

  a_result_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_accept))
    else $error("result appeared without an accepted beat");
`endif

endmodule
